>>> sv/tvd_pkg.sv
// ----------------------------------------------------------------------------
// tvd_pkg
// Shared constants, types and compare functions for the vertex dedup block.
// ----------------------------------------------------------------------------
package tvd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_W    = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int TRI_W      = 16;
    localparam logic [TRI_W-1:0] TRI_MAX = {TRI_W{1'b1}};
    localparam logic [COORD_W-2:0] EXP_ALL_ONES = 31'h7F80_0000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
        logic append;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic append_end;
    } t_status;

    // IEEE single equality: +0 == -0, NaN equals nothing
    function automatic logic coord_eq(input logic [COORD_W-1:0] u,
                                      input logic [COORD_W-1:0] v);
        logic [COORD_W-2:0] mu;
        logic [COORD_W-2:0] mv;
        mu = u[COORD_W-2:0];
        mv = v[COORD_W-2:0];
        if ((mu > EXP_ALL_ONES) || (mv > EXP_ALL_ONES)) begin
            return 1'b0;
        end
        if ((mu == '0) && (mv == '0)) begin
            return 1'b1;
        end
        return u == v;
    endfunction

    function automatic logic point_eq(input t_point p, input t_point q);
        return coord_eq(p.x, q.x) && coord_eq(p.y, q.y) && coord_eq(p.z, q.z);
    endfunction

endpackage

>>> sv/tvd_ctrl.sv
// ----------------------------------------------------------------------------
// tvd_ctrl
// Sequencer: load, scan the point store, resolve indices, append, report.
// ----------------------------------------------------------------------------
module tvd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tvd_pkg::t_status  i_status,
    output tvd_pkg::t_cmd     o_cmd,
    output logic              busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_RESOLVE = 3'd2;
    localparam logic [2:0] S_APPEND  = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_end) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = S_APPEND;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                if (i_status.append_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> sv/tvd_dpath.sv
// ----------------------------------------------------------------------------
// tvd_dpath
// Point store, scan comparators, index resolution and result registers.
// ----------------------------------------------------------------------------
module tvd_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tvd_pkg::t_cmd                     i_cmd,
    output tvd_pkg::t_status                  o_status,
    input  logic [tvd_pkg::COORD_W-1:0]       i_a_x,
    input  logic [tvd_pkg::COORD_W-1:0]       i_a_y,
    input  logic [tvd_pkg::COORD_W-1:0]       i_a_z,
    input  logic [tvd_pkg::COORD_W-1:0]       i_b_x,
    input  logic [tvd_pkg::COORD_W-1:0]       i_b_y,
    input  logic [tvd_pkg::COORD_W-1:0]       i_b_z,
    input  logic [tvd_pkg::COORD_W-1:0]       i_c_x,
    input  logic [tvd_pkg::COORD_W-1:0]       i_c_y,
    input  logic [tvd_pkg::COORD_W-1:0]       i_c_z,
    output logic                              o_valid,
    output logic [tvd_pkg::IDX_W-1:0]         o_index_a,
    output logic [tvd_pkg::IDX_W-1:0]         o_index_b,
    output logic [tvd_pkg::IDX_W-1:0]         o_index_c,
    output logic [tvd_pkg::CNT_W-1:0]         o_unique_count,
    output logic [tvd_pkg::TRI_W-1:0]         o_triangles_seen,
    output logic                              o_overflow
);

    localparam int IW = tvd_pkg::IDX_W;
    localparam int CW = tvd_pkg::CNT_W;

    tvd_pkg::t_point r_mem [tvd_pkg::MAX_POINTS];

    tvd_pkg::t_point r_vtx_a, r_vtx_b, r_vtx_c;
    tvd_pkg::t_point r_rd_data;
    tvd_pkg::t_point wr_data;

    logic [2:0]    r_found;
    logic [IW-1:0] r_fidx_a, r_fidx_b, r_fidx_c;
    logic [CW-1:0] r_addr;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_addr;
    logic [CW-1:0] r_total;
    logic [tvd_pkg::TRI_W-1:0] r_tri;

    logic [IW-1:0] r_idx_a, r_idx_b, r_idx_c;
    logic [1:0]    r_np;
    logic          r_ovf;
    logic [2:0]    r_mask;
    logic [CW-1:0] r_wr_ptr;

    logic          r_valid;
    logic [IW-1:0] r_o_idx_a, r_o_idx_b, r_o_idx_c;
    logic [CW-1:0] r_o_count;
    logic [tvd_pkg::TRI_W-1:0] r_o_tri;
    logic          r_o_ovf;

    logic          rd_en, wr_en;
    logic          eq_ab, eq_ac, eq_bc;
    logic          new_a, new_b, new_c;
    logic [CW-1:0] n_idx_a, n_idx_b, n_idx_c;
    logic [1:0]    n_np;
    logic          n_ovf;
    logic [CW-1:0] n_total;
    logic [tvd_pkg::TRI_W-1:0] n_tri;

    assign o_status.scan_end   = (r_addr == r_total);
    assign o_status.append_end = (r_mask == 3'b000);

    assign rd_en = i_cmd.scan && !o_status.scan_end;
    assign wr_en = i_cmd.append && (r_mask != 3'b000);

    always_comb begin
        if (r_mask[0]) begin
            wr_data = r_vtx_a;
        end else if (r_mask[1]) begin
            wr_data = r_vtx_b;
        end else begin
            wr_data = r_vtx_c;
        end
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr[IW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[IW-1:0]];
        end
    end

    // index resolution, vertices matched against earlier appends of this triangle
    always_comb begin
        eq_ab   = tvd_pkg::point_eq(r_vtx_a, r_vtx_b);
        eq_ac   = tvd_pkg::point_eq(r_vtx_a, r_vtx_c);
        eq_bc   = tvd_pkg::point_eq(r_vtx_b, r_vtx_c);
        new_a   = !r_found[0];
        new_b   = 1'b0;
        new_c   = 1'b0;
        n_idx_a = r_found[0] ? {1'b0, r_fidx_a} : r_total;
        if (r_found[1]) begin
            n_idx_b = {1'b0, r_fidx_b};
        end else if (new_a && eq_ab) begin
            n_idx_b = r_total;
        end else begin
            new_b   = 1'b1;
            n_idx_b = r_total + CW'(new_a);
        end
        if (r_found[2]) begin
            n_idx_c = {1'b0, r_fidx_c};
        end else if (new_a && eq_ac) begin
            n_idx_c = r_total;
        end else if (new_b && eq_bc) begin
            n_idx_c = n_idx_b;
        end else begin
            new_c   = 1'b1;
            n_idx_c = r_total + CW'(new_a) + CW'(new_b);
        end
        n_np  = 2'(new_a) + 2'(new_b) + 2'(new_c);
        n_ovf = ({1'b0, r_total} + (CW+1)'(n_np)) > (CW+1)'(tvd_pkg::MAX_POINTS);
    end

    assign n_total = r_total + CW'(r_np);
    assign n_tri   = (r_tri == tvd_pkg::TRI_MAX) ? r_tri : r_tri + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vtx_a <= '{x: i_a_x, y: i_a_y, z: i_a_z};
            r_vtx_b <= '{x: i_b_x, y: i_b_y, z: i_b_z};
            r_vtx_c <= '{x: i_c_x, y: i_c_y, z: i_c_z};
        end
        if (rd_en) begin
            r_rd_addr <= r_addr[IW-1:0];
        end
        if (r_rd_vld) begin
            if (!r_found[0] && tvd_pkg::point_eq(r_rd_data, r_vtx_a)) begin
                r_fidx_a <= r_rd_addr;
            end
            if (!r_found[1] && tvd_pkg::point_eq(r_rd_data, r_vtx_b)) begin
                r_fidx_b <= r_rd_addr;
            end
            if (!r_found[2] && tvd_pkg::point_eq(r_rd_data, r_vtx_c)) begin
                r_fidx_c <= r_rd_addr;
            end
        end
        if (i_cmd.resolve) begin
            r_idx_a  <= n_idx_a[IW-1:0];
            r_idx_b  <= n_idx_b[IW-1:0];
            r_idx_c  <= n_idx_c[IW-1:0];
            r_np     <= n_np;
            r_ovf    <= n_ovf;
            r_wr_ptr <= r_total;
        end else if (wr_en) begin
            r_wr_ptr <= r_wr_ptr + 1'b1;
        end
        if (i_cmd.finish) begin
            r_o_ovf <= r_ovf;
            if (r_ovf) begin
                r_o_idx_a <= '0;
                r_o_idx_b <= '0;
                r_o_idx_c <= '0;
                r_o_count <= r_total;
                r_o_tri   <= r_tri;
            end else begin
                r_o_idx_a <= r_idx_a;
                r_o_idx_b <= r_idx_b;
                r_o_idx_c <= r_idx_c;
                r_o_count <= n_total;
                r_o_tri   <= n_tri;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_total  <= '0;
            r_tri    <= '0;
            r_mask   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            r_valid  <= i_cmd.finish;
            if (i_cmd.load) begin
                r_found <= '0;
                r_addr  <= '0;
            end else begin
                if (rd_en) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_rd_vld) begin
                    r_found <= r_found | {
                        tvd_pkg::point_eq(r_rd_data, r_vtx_c),
                        tvd_pkg::point_eq(r_rd_data, r_vtx_b),
                        tvd_pkg::point_eq(r_rd_data, r_vtx_a)};
                end
            end
            if (i_cmd.resolve) begin
                r_mask <= n_ovf ? 3'b000 : {new_c, new_b, new_a};
            end else if (wr_en) begin
                r_mask <= r_mask & (r_mask - 3'b001);
            end
            if (i_cmd.finish && !r_ovf) begin
                r_total <= n_total;
                r_tri   <= n_tri;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_index_a        = r_o_idx_a;
    assign o_index_b        = r_o_idx_b;
    assign o_index_c        = r_o_idx_c;
    assign o_unique_count   = r_o_count;
    assign o_triangles_seen = r_o_tri;
    assign o_overflow       = r_o_ovf;

`ifndef NO_ASSERTIONS
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_wr_ptr < CW'(tvd_pkg::MAX_POINTS)))
        else $error("append beyond point store");

    a_rd_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ({1'b0, r_rd_addr} < r_total))
        else $error("scan read past stored points");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(tvd_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

>>> sv/triangle_vertex_dedup_top.sv
// ----------------------------------------------------------------------------
// triangle_vertex_dedup_top
// Welds triangle vertices into a store of unique points and returns indices.
//
//   channel   direction  handshake           payload
//   input     in         start / busy        i_a_* i_b_* i_c_* (x, y, z)
//   result    out        o_valid strobe      o_index_a/b/c, o_unique_count,
//                                            o_triangles_seen, o_overflow
//
// A transfer is taken when start is high and busy is low.
// The scan reads each stored point once, one store entry per cycle through a
// single port; then 0..3 new points are appended to the store.
// The result strobe is high in the first cycle with busy low and cannot be stalled.
// Synchronous active-low reset empties the store and clears both counters;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module triangle_vertex_dedup_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tvd_pkg::COORD_W-1:0]       i_a_x,
    input  logic [tvd_pkg::COORD_W-1:0]       i_a_y,
    input  logic [tvd_pkg::COORD_W-1:0]       i_a_z,
    input  logic [tvd_pkg::COORD_W-1:0]       i_b_x,
    input  logic [tvd_pkg::COORD_W-1:0]       i_b_y,
    input  logic [tvd_pkg::COORD_W-1:0]       i_b_z,
    input  logic [tvd_pkg::COORD_W-1:0]       i_c_x,
    input  logic [tvd_pkg::COORD_W-1:0]       i_c_y,
    input  logic [tvd_pkg::COORD_W-1:0]       i_c_z,
    output logic                              o_valid,
    output logic [tvd_pkg::IDX_W-1:0]         o_index_a,
    output logic [tvd_pkg::IDX_W-1:0]         o_index_b,
    output logic [tvd_pkg::IDX_W-1:0]         o_index_c,
    output logic [tvd_pkg::CNT_W-1:0]         o_unique_count,
    output logic [tvd_pkg::TRI_W-1:0]         o_triangles_seen,
    output logic                              o_overflow
);

    tvd_pkg::t_cmd    cmd;
    tvd_pkg::t_status status;

    tvd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    tvd_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_a_x            (i_a_x),
        .i_a_y            (i_a_y),
        .i_a_z            (i_a_z),
        .i_b_x            (i_b_x),
        .i_b_y            (i_b_y),
        .i_b_z            (i_b_z),
        .i_c_x            (i_c_x),
        .i_c_y            (i_c_y),
        .i_c_z            (i_c_z),
        .o_valid          (o_valid),
        .o_index_a        (o_index_a),
        .o_index_b        (o_index_b),
        .o_index_c        (o_index_c),
        .o_unique_count   (o_unique_count),
        .o_triangles_seen (o_triangles_seen),
        .o_overflow       (o_overflow)
    );

endmodule
